[design/pcs_pkg.sv]
// pcs_pkg: shared types and constants for the polyline centroid stream unit.
// Beat structs, sequencer state types and the shared root/divide unit request/status.
// No dependencies.
package pcs_pkg;

	localparam int COORD_W    = 24;              // coordinate width
	localparam int LEN_W      = 36;              // total length width
	localparam int SUM_W      = 62;              // weighted sum width
	localparam int MAG_W      = COORD_W + 1;     // |dx|, |x + prev x|, segment length
	localparam int PROD_W     = 2 * MAG_W;       // multiplier product
	localparam int SQ_W       = 2 * COORD_W + 1; // dx^2 + dy^2
	localparam int REM_W      = SUM_W + 1;       // compare/subtract datapath width
	localparam int DEN_W      = LEN_W + 1;       // twice the total length
	localparam int QUO_W      = COORD_W + 1;     // clipped quotient / root
	localparam int ROOT_STEPS = MAG_W;           // one root bit per step
	localparam int DIV_STEPS  = COORD_W;         // one quotient bit per step
	localparam int CNT_W      = 5;

	// quotient marker when it is at least 2^DIV_STEPS
	localparam logic [QUO_W-1:0] QUO_SAT = QUO_W'(1) << DIV_STEPS;
	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (COORD_W - 1);
	localparam logic [QUO_W-1:0] POS_LIM = NEG_LIM - QUO_W'(1);

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic                      last_vertex;
	} in_beat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] centroid_x;
		logic signed [COORD_W-1:0] centroid_y;
		logic [LEN_W-1:0]          total_length;
	} out_beat_t;

	typedef enum logic {
		OP_ROOT,
		OP_DIV
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] result;
	} unit_stat_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_ROOT,
		U_PRE,
		U_DIV
	} unit_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_SUMSQ,
		S_ROOT_GO,
		S_ROOT_WAIT,
		S_MULX,
		S_ADDX,
		S_ADDY,
		S_LAST,
		S_DIVX_GO,
		S_DIVX_WAIT,
		S_DIVY_GO,
		S_DIVY_WAIT,
		S_EMIT
	} seq_state_t;

endpackage

[design/pcs_root_div.sv]
// pcs_root_div: shared compare/subtract unit, bit-serial square root or clipped division.
// Depends on pcs_pkg.
module pcs_root_div
	import pcs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  unit_req_t        req,
	input  logic [REM_W-1:0] opa,
	input  logic [DEN_W-1:0] den,
	output unit_stat_t       stat
);

	unit_state_t      state_q, state_d;
	unit_op_t         op_q;
	logic [REM_W-1:0] rem_q, acc_q, sub_b;
	logic [SQ_W-1:0]  bit_q;
	logic [QUO_W-1:0] q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q, fin;
	logic [REM_W:0]   diff;
	logic             ge, last_step;

	// one compare/subtract shared by both operations
	assign sub_b     = (state_q == U_ROOT) ? (acc_q | REM_W'(bit_q)) : acc_q;
	assign diff      = {1'b0, rem_q} - {1'b0, sub_b};
	assign ge        = ~diff[REM_W];
	assign last_step = (cnt_q == '0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE: begin
				if (req.start)
					state_d = (req.op == OP_ROOT) ? U_ROOT : U_PRE;
			end
			U_ROOT: begin
				if (last_step)
					state_d = U_IDLE;
			end
			U_PRE: begin
				state_d = ge ? U_IDLE : U_DIV;
			end
			U_DIV: begin
				if (last_step)
					state_d = U_IDLE;
			end
			default: state_d = U_IDLE;
		endcase
	end

	always_comb begin
		fin = 1'b0;
		case (state_q)
			U_ROOT, U_DIV: fin = last_step;
			U_PRE:         fin = ge;
			default:       fin = 1'b0;
		endcase
		stat.done   = done_q;
		stat.result = (op_q == OP_ROOT) ? acc_q[QUO_W-1:0] : q_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					rem_q <= opa;
					q_q   <= '0;
					bit_q <= {1'b1, {(SQ_W-1){1'b0}}};
					if (req.op == OP_ROOT) begin
						acc_q <= '0;
						cnt_q <= CNT_W'(ROOT_STEPS - 1);
					end else begin
						acc_q <= REM_W'(den) << DIV_STEPS;
						cnt_q <= CNT_W'(DIV_STEPS - 1);
					end
				end
			end
			U_ROOT: begin
				if (ge)
					rem_q <= diff[REM_W-1:0];
				acc_q <= ge ? ((acc_q >> 1) | REM_W'(bit_q)) : (acc_q >> 1);
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			U_PRE: begin
				// quotient would not fit: flag it and stop
				if (ge)
					q_q <= QUO_SAT;
				acc_q <= acc_q >> 1;
			end
			U_DIV: begin
				if (ge)
					rem_q <= diff[REM_W-1:0];
				acc_q <= acc_q >> 1;
				q_q   <= {q_q[QUO_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

endmodule

[design/polyline_centroid_stream_unit.sv]
// polyline_centroid_stream_unit: length weighted centroid of a streamed polyline.
// Top level; depends on pcs_pkg and pcs_root_div.
//
// Vertices arrive one beat at a time as signed 24-bit fixed point x,y (any number of
// fraction bits; the unit is scale free). Each segment length is the floor square root
// of dx^2 + dy^2; zero-length segments are skipped. The unit keeps the saturating total
// length (36 bits) and the sums of length * (x + prev x) and length * (y + prev y),
// wrapping at 62 bits. On the beat flagged last_vertex it returns one result beat: each
// sum divided by twice the total, truncated toward zero and saturated to the 24-bit
// range, plus the total length. A lone vertex, or a zero total, returns the first vertex
// and a total of zero. After the result the unit starts a fresh polyline.
// Sequencing: one vertex is worked on at a time and in_ready is low meanwhile. The
// first vertex of a polyline needs no root; every later vertex goes through the
// 25-step bit-serial square root in the shared root/divide unit (a zero-length segment
// then skips the length and sum updates), plus one 25x25 multiplier used for dx^2,
// dy^2 and both weighted products. The last vertex adds two 24-step divisions through
// the same unit (a quotient of 2^24 or more is caught by a pre-check and skips the
// division steps), or none when the total is zero.
// The result sits in an output register, so the next polyline is taken in while it
// waits; only a second result waits for the first to leave.
module polyline_centroid_stream_unit
	import pcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	seq_state_t state_q, state_d;

	// polyline state
	logic                      seen_q;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [LEN_W-1:0]          total_q;
	logic [SUM_W-1:0]          sum_x_q, sum_y_q;

	// per-vertex working registers
	logic                      last_q;
	logic [MAG_W-1:0]          dx_q, dy_q, px_q, py_q, len_q;
	logic                      px_neg_q, py_neg_q;
	logic [PROD_W-1:0]         prod_q;
	logic [SQ_W-1:0]           sq_q;
	logic [COORD_W-1:0]        cx_q, cy_q;

	// output register
	logic                      out_valid_q;
	out_beat_t                 out_q;

	// shared unit hookup
	unit_req_t                 req;
	unit_stat_t                stat;
	logic [REM_W-1:0]          unit_a;
	logic [DEN_W-1:0]          unit_den;

	logic [MAG_W-1:0]          mul_a, mul_b;
	logic                      accept, out_free, emit;

	// vertex differences and pair sums, 25-bit signed
	logic signed [MAG_W-1:0]   dx_s, dy_s, px_s, py_s;
	logic [SUM_W-1:0]          sum_sel, prod_ext;
	logic                      sum_neg;
	logic [LEN_W:0]            total_add;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == S_EMIT) && out_free;

	assign dx_s = MAG_W'(in_data.x_coord) - MAG_W'(prev_x_q);
	assign dy_s = MAG_W'(in_data.y_coord) - MAG_W'(prev_y_q);
	assign px_s = MAG_W'(in_data.x_coord) + MAG_W'(prev_x_q);
	assign py_s = MAG_W'(in_data.y_coord) + MAG_W'(prev_y_q);

	// clamp an unsigned quotient into the signed coordinate range
	function automatic logic [COORD_W-1:0] clamp_coord(input logic neg,
		input logic [QUO_W-1:0] q);
		logic [QUO_W-1:0] qq;
		if (neg) begin
			qq = (q > NEG_LIM) ? NEG_LIM : q;
			qq = ~qq + QUO_W'(1);
		end else begin
			qq = (q > POS_LIM) ? POS_LIM : q;
		end
		return qq[COORD_W-1:0];
	endfunction

	pcs_root_div u_root_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (unit_a),
		.den    (unit_den),
		.stat   (stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = seen_q ? S_SQX : S_LAST;
			end
			S_SQX:     state_d = S_SQY;
			S_SQY:     state_d = S_SUMSQ;
			S_SUMSQ:   state_d = S_ROOT_GO;
			S_ROOT_GO: state_d = S_ROOT_WAIT;
			S_ROOT_WAIT: begin
				if (stat.done)
					state_d = (stat.result == '0) ? S_LAST : S_MULX;
			end
			S_MULX: state_d = S_ADDX;
			S_ADDX: state_d = S_ADDY;
			S_ADDY: state_d = S_LAST;
			S_LAST: begin
				if (!last_q)
					state_d = S_IDLE;
				else if (total_q == '0)
					state_d = S_EMIT;
				else
					state_d = S_DIVX_GO;
			end
			S_DIVX_GO: state_d = S_DIVX_WAIT;
			S_DIVX_WAIT: begin
				if (stat.done)
					state_d = S_DIVY_GO;
			end
			S_DIVY_GO: state_d = S_DIVY_WAIT;
			S_DIVY_WAIT: begin
				if (stat.done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs and operand selection
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		req.start = 1'b0;
		req.op    = OP_DIV;
		mul_a     = dx_q;
		mul_b     = dx_q;
		sum_sel   = sum_x_q;
		case (state_q)
			S_ROOT_GO: begin
				req.start = 1'b1;
				req.op    = OP_ROOT;
			end
			S_DIVX_GO: req.start = 1'b1;
			S_DIVY_GO: begin
				req.start = 1'b1;
				sum_sel   = sum_y_q;
			end
			S_SQY: begin
				mul_a = dy_q;
				mul_b = dy_q;
			end
			S_MULX: begin
				mul_a = len_q;
				mul_b = px_q;
			end
			S_ADDX: begin
				mul_a = len_q;
				mul_b = py_q;
			end
			default: ;
		endcase
		// divide by the magnitude of the sum, sign handled on the quotient
		sum_neg  = sum_sel[SUM_W-1];
		unit_den = {total_q, 1'b0};
		if (state_q == S_ROOT_GO)
			unit_a = REM_W'(sq_q);
		else if (sum_neg)
			unit_a = (REM_W'(1) << SUM_W) - {1'b0, sum_sel};
		else
			unit_a = {1'b0, sum_sel};
	end

	assign prod_ext  = SUM_W'(prod_q);
	assign total_add = {1'b0, total_q} + (LEN_W + 1)'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seen_q      <= 1'b0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			total_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (accept) begin
				seen_q   <= 1'b1;
				prev_x_q <= in_data.x_coord;
				prev_y_q <= in_data.y_coord;
				if (!seen_q) begin
					first_x_q <= in_data.x_coord;
					first_y_q <= in_data.y_coord;
				end
			end

			case (state_q)
				S_MULX: begin
					// saturate the running length
					total_q <= total_add[LEN_W] ? {LEN_W{1'b1}} : total_add[LEN_W-1:0];
				end
				S_ADDX: sum_x_q <= sum_x_q + (px_neg_q ? (~prod_ext + SUM_W'(1)) : prod_ext);
				S_ADDY: sum_y_q <= sum_y_q + (py_neg_q ? (~prod_ext + SUM_W'(1)) : prod_ext);
				default: ;
			endcase

			// result loaded into the output register: start a fresh polyline
			if (emit) begin
				seen_q    <= 1'b0;
				first_x_q <= '0;
				first_y_q <= '0;
				prev_x_q  <= '0;
				prev_y_q  <= '0;
				total_q   <= '0;
				sum_x_q   <= '0;
				sum_y_q   <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (accept) begin
			last_q   <= in_data.last_vertex;
			dx_q     <= dx_s[MAG_W-1] ? MAG_W'(-dx_s) : MAG_W'(dx_s);
			dy_q     <= dy_s[MAG_W-1] ? MAG_W'(-dy_s) : MAG_W'(dy_s);
			px_q     <= px_s[MAG_W-1] ? MAG_W'(-px_s) : MAG_W'(px_s);
			py_q     <= py_s[MAG_W-1] ? MAG_W'(-py_s) : MAG_W'(py_s);
			px_neg_q <= px_s[MAG_W-1];
			py_neg_q <= py_s[MAG_W-1];
		end

		case (state_q)
			S_SQY:   sq_q <= prod_q[SQ_W-1:0];
			S_SUMSQ: sq_q <= sq_q + prod_q[SQ_W-1:0];
			S_ROOT_WAIT: begin
				if (stat.done)
					len_q <= stat.result;
			end
			S_LAST: begin
				cx_q <= first_x_q;
				cy_q <= first_y_q;
			end
			S_DIVX_WAIT: begin
				if (stat.done)
					cx_q <= clamp_coord(sum_x_q[SUM_W-1], stat.result);
			end
			S_DIVY_WAIT: begin
				if (stat.done)
					cy_q <= clamp_coord(sum_y_q[SUM_W-1], stat.result);
			end
			default: ;
		endcase

		if (emit) begin
			out_q.centroid_x   <= cx_q;
			out_q.centroid_y   <= cy_q;
			out_q.total_length <= total_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[design/pcs_checker.sv]
// pcs_checker: port-level assertions for polyline_centroid_stream_unit.
// Depends on pcs_pkg; bound to the top level at the end of this file.
module pcs_checker
	import pcs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_beat_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);

	// last-vertex beats taken whose result beat has not gone out yet
	logic [1:0] pend_q;
	logic       last_in, res_out;

	assign last_in = in_valid && in_ready && in_data.last_vertex;
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + {1'b0, last_in} - {1'b0, res_out};
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("vertex beat taken while previous still in work");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result beat without a last vertex");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> !in_ready)
		else $error("third polyline accepted with two results owed");

endmodule

bind polyline_centroid_stream_unit pcs_checker u_pcs_checker (.*);
